### rtl/vr3_pkg.sv
// Shared types and constants for the 3D vector reflection unit.
// No dependencies; imported by vr3_norm and vector_reflection_3d_unit.
package vr3_pkg;

	// The normaliser scales every vector so that its largest component magnitude
	// has its leading one at bit NRM_W-1.
	localparam int NRM_W      = 30;
	// Width of the sum of three squared scaled magnitudes.
	localparam int SQ_W       = 62;
	// One square root step per stage, two radicand bits per step.
	localparam int ROOT_STEPS = 31;
	// Width of the integer square root of an SQ_W bit value.
	localparam int ROOT_W     = 31;

	// Status that leaves a normaliser alongside its vector.
	typedef struct packed {
		logic valid;
		logic zero;
	} vr3_stat_t;

endpackage

### rtl/vr3_norm.sv
// Pipelined fixed-point 3D vector normaliser: block scaling, squares, a one-step-per-stage
// square root and a one-bit-per-stage divider. Depends on vr3_pkg.
module vr3_norm
	import vr3_pkg::*;
#(
	parameter int IN_WIDTH        = 16,
	parameter int COMPONENT_WIDTH = 16,
	parameter int FRACTION_BITS   = 14,
	parameter int SIDE_WIDTH      = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid,
	input  logic [2:0]                          neg,
	input  logic [2:0][IN_WIDTH-1:0]            mag,
	input  logic [SIDE_WIDTH-1:0]               side,
	output vr3_stat_t                           stat,
	output logic [2:0][COMPONENT_WIDTH-1:0]     vec,
	output logic [SIDE_WIDTH-1:0]               side_out
);

	localparam int F         = FRACTION_BITS;
	localparam int PW        = $clog2(IN_WIDTH);
	localparam int SHW       = IN_WIDTH + NRM_W - 1;
	localparam int QW        = F + 1;
	localparam int DW        = ROOT_W + 1;
	localparam int NW        = DW + F + 1;
	localparam int DIV_STEPS = QW;
	localparam longint LIM_L = (F <= COMPONENT_WIDTH - 2) ? (64'd1 << F)
		: ((64'd1 << (COMPONENT_WIDTH - 1)) - 64'd1);
	localparam logic [QW-1:0] LIM = QW'(LIM_L);
	localparam int EW = ((QW > COMPONENT_WIDTH) ? QW : COMPONENT_WIDTH) + 1;

	// Stage 1: largest magnitude.
	logic [IN_WIDTH-1:0]       mx;
	logic                      v_s1;
	logic [2:0]                neg_s1;
	logic [2:0][IN_WIDTH-1:0]  mag_s1;
	logic [IN_WIDTH-1:0]       mx_s1;
	logic [SIDE_WIDTH-1:0]     side_s1;

	always_comb begin
		mx = mag[0];
		if (mag[1] > mx) begin
			mx = mag[1];
		end
		if (mag[2] > mx) begin
			mx = mag[2];
		end
	end

	// Stage 2: leading one of the largest magnitude.
	logic [PW-1:0]             pos;
	logic                      v_s2;
	logic [2:0]                neg_s2;
	logic [2:0][IN_WIDTH-1:0]  mag_s2;
	logic [PW-1:0]             pos_s2;
	logic                      zero_s2;
	logic [SIDE_WIDTH-1:0]     side_s2;

	always_comb begin
		pos = '0;
		for (int i = 0; i < IN_WIDTH; i++) begin
			if (mx_s1[i]) begin
				pos = PW'(i);
			end
		end
	end

	// Stage 3: scaled magnitudes, right shifts truncate.
	logic [2:0][SHW-1:0]       shf;
	logic                      v_s3;
	logic [2:0]                neg_s3;
	logic [2:0][NRM_W-1:0]     a_s3;
	logic                      zero_s3;
	logic [SIDE_WIDTH-1:0]     side_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shf[i] = {mag_s2[i], {(NRM_W-1){1'b0}}} >> pos_s2;
		end
	end

	// Stage 4: squares.
	logic                        v_s4;
	logic [2:0]                  neg_s4;
	logic [2:0][NRM_W-1:0]       a_s4;
	logic [2:0][2*NRM_W-1:0]     sq_s4;
	logic                        zero_s4;
	logic [SIDE_WIDTH-1:0]       side_s4;

	// Square root pipeline, index 0 is the stage that forms the sum of squares.
	logic                        rv_s [ROOT_STEPS+1];
	logic [SQ_W-1:0]             rx_s [ROOT_STEPS+1];
	logic [SQ_W-1:0]             rr_s [ROOT_STEPS+1];
	logic [2:0][NRM_W-1:0]       ra_s [ROOT_STEPS+1];
	logic [2:0]                  rn_s [ROOT_STEPS+1];
	logic                        rz_s [ROOT_STEPS+1];
	logic [SIDE_WIDTH-1:0]       rs_s [ROOT_STEPS+1];

	// Divider pipeline, index 0 is the stage that forms numerators and divisor.
	logic                        dv_s [DIV_STEPS+1];
	logic [2:0][NW-1:0]          dn_s [DIV_STEPS+1];
	logic [DW-1:0]               dd_s [DIV_STEPS+1];
	logic [2:0][QW-1:0]          dq_s [DIV_STEPS+1];
	logic [2:0]                  dg_s [DIV_STEPS+1];
	logic                        dz_s [DIV_STEPS+1];
	logic [SIDE_WIDTH-1:0]       ds_s [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			rv_s[0]  <= 1'b0;
			dv_s[0]  <= 1'b0;
			stat     <= '0;
		end else if (en) begin
			v_s1       <= valid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			rv_s[0]    <= v_s4;
			dv_s[0]    <= rv_s[ROOT_STEPS];
			stat.valid <= dv_s[DIV_STEPS];
			stat.zero  <= dz_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= neg;
			mag_s1  <= mag;
			mx_s1   <= mx;
			side_s1 <= side;

			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			pos_s2  <= pos;
			zero_s2 <= (mx_s1 == '0);
			side_s2 <= side_s1;

			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			side_s3 <= side_s2;
			for (int i = 0; i < 3; i++) begin
				a_s3[i] <= shf[i][NRM_W-1:0];
			end

			neg_s4  <= neg_s3;
			a_s4    <= a_s3;
			zero_s4 <= zero_s3;
			side_s4 <= side_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= a_s3[i] * a_s3[i];
			end

			rx_s[0] <= SQ_W'(sq_s4[0]) + SQ_W'(sq_s4[1]) + SQ_W'(sq_s4[2]);
			rr_s[0] <= '0;
			ra_s[0] <= a_s4;
			rn_s[0] <= neg_s4;
			rz_s[0] <= zero_s4;
			rs_s[0] <= side_s4;

			dd_s[0] <= {rr_s[ROOT_STEPS][ROOT_W-1:0], 1'b0};
			dq_s[0] <= '0;
			dg_s[0] <= rn_s[ROOT_STEPS];
			dz_s[0] <= rz_s[ROOT_STEPS];
			ds_s[0] <= rs_s[ROOT_STEPS];
			for (int i = 0; i < 3; i++) begin
				dn_s[0][i] <= (NW'(ra_s[ROOT_STEPS][i]) << (F + 1))
					+ NW'(rr_s[ROOT_STEPS][ROOT_W-1:0]);
			end
		end
	end

	// One result bit of the square root per stage.
	for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - j));
		logic [SQ_W:0] trial;
		logic          take;

		assign trial = {1'b0, rr_s[j]} + {1'b0, BIT};
		assign take  = ({1'b0, rx_s[j]} >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[j+1] <= 1'b0;
			end else if (en) begin
				rv_s[j+1] <= rv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[j+1] <= take ? (rx_s[j] - trial[SQ_W-1:0]) : rx_s[j];
				rr_s[j+1] <= take ? ((rr_s[j] >> 1) + BIT) : (rr_s[j] >> 1);
				ra_s[j+1] <= ra_s[j];
				rn_s[j+1] <= rn_s[j];
				rz_s[j+1] <= rz_s[j];
				rs_s[j+1] <= rs_s[j];
			end
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int K = F - j;
		logic [NW-1:0] dsh;

		assign dsh = NW'(dd_s[j]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_s[j+1] <= dv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (dn_s[j][i] >= dsh) begin
						dn_s[j+1][i] <= dn_s[j][i] - dsh;
						dq_s[j+1][i] <= dq_s[j][i] | (QW'(1) << K);
					end else begin
						dn_s[j+1][i] <= dn_s[j][i];
						dq_s[j+1][i] <= dq_s[j][i];
					end
				end
				dd_s[j+1] <= dd_s[j];
				dg_s[j+1] <= dg_s[j];
				dz_s[j+1] <= dz_s[j];
				ds_s[j+1] <= ds_s[j];
			end
		end
	end

	// Final stage: clamp to the largest representable unit value and apply the sign.
	logic [2:0][EW-1:0] sgn;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sgn[i] = EW'((dq_s[DIV_STEPS][i] > LIM) ? LIM : dq_s[DIV_STEPS][i]);
			if (dg_s[DIV_STEPS][i]) begin
				sgn[i] = -sgn[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vec[i] <= sgn[i][COMPONENT_WIDTH-1:0];
			end
			side_out <= ds_s[DIV_STEPS];
		end
	end

endmodule

### rtl/vector_reflection_3d_unit.sv
// Top level of the 3D vector reflection unit: input normaliser, reflection arithmetic,
// output normaliser. Depends on vr3_pkg and vr3_norm.

// The unit reflects an incident vector about a surface normal and returns the reflected
// unit vector in the same fixed-point format as the normal. It is fully pipelined: one
// item may enter in every clock cycle while the pipeline is not held. Most of the latency
// lies in the two normalisers, each of which computes an integer square root one result
// bit per stage and divides one quotient bit per stage. The whole pipeline advances
// together; it holds only while a result sits at the output and the receiver stalls, and
// any bubbles in flight are held along with it. When the incident vector is zero, or the
// reflected sum comes out as zero, degenerate is set and the three components read zero.
// The normal is used as given, even when it is not of unit length.
module vector_reflection_3d_unit
	import vr3_pkg::*;
#(
	parameter int COMPONENT_WIDTH = 16,
	parameter int FRACTION_BITS   = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [COMPONENT_WIDTH-1:0] incident_x,
	input  logic signed [COMPONENT_WIDTH-1:0] incident_y,
	input  logic signed [COMPONENT_WIDTH-1:0] incident_z,
	input  logic signed [COMPONENT_WIDTH-1:0] normal_x,
	input  logic signed [COMPONENT_WIDTH-1:0] normal_y,
	input  logic signed [COMPONENT_WIDTH-1:0] normal_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [COMPONENT_WIDTH-1:0] reflected_x,
	output logic signed [COMPONENT_WIDTH-1:0] reflected_y,
	output logic signed [COMPONENT_WIDTH-1:0] reflected_z,
	output logic                              degenerate
);

	localparam int CW   = COMPONENT_WIDTH;
	localparam int F    = FRACTION_BITS;
	// Width of the rounded reflection coefficient magnitude.
	localparam int CMW  = CW + 2;
	// Width of the product of that coefficient with a normal magnitude.
	localparam int PRW  = CMW + CW;
	// Width that holds the magnitude of any reflected sum component.
	localparam int RW_A = 2 * CW + 4 - F;
	localparam int RW_B = F + 2;
	localparam int RW   = (RW_A > RW_B) ? RW_A : RW_B;
	localparam int DTW  = 2 * CW + 2;

	// The pipeline moves as one; it stops only when a finished item is refused.
	logic en;
	logic accept;

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;
	assign accept   = in_valid && en;

	// Incident vector into sign and magnitude form; the normal rides along as side data.
	logic signed [CW-1:0] inc [3];
	logic [2:0]           inc_neg;
	logic [2:0][CW-1:0]   inc_mag;

	assign inc[0] = incident_x;
	assign inc[1] = incident_y;
	assign inc[2] = incident_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			inc_neg[i] = inc[i][CW-1];
			inc_mag[i] = inc_neg[i] ? CW'(-inc[i]) : CW'(inc[i]);
		end
	end

	vr3_stat_t          stat1;
	logic [2:0][CW-1:0] vn1;
	logic [3*CW-1:0]    nrm1;

	vr3_norm #(
		.IN_WIDTH        (CW),
		.COMPONENT_WIDTH (CW),
		.FRACTION_BITS   (F),
		.SIDE_WIDTH      (3 * CW)
	) u_norm_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (accept),
		.neg      (inc_neg),
		.mag      (inc_mag),
		.side     ({normal_z, normal_y, normal_x}),
		.stat     (stat1),
		.vec      (vn1),
		.side_out (nrm1)
	);

	// Stage 1: products of the normal with the normalised incident vector.
	logic                   v_s1, z_s1;
	logic signed [CW-1:0]   n_s1 [3];
	logic signed [CW-1:0]   vn_s1 [3];
	logic signed [2*CW-1:0] prod_s1 [3];

	// Stage 2: dot product.
	logic                   v_s2, z_s2;
	logic signed [CW-1:0]   n_s2 [3];
	logic signed [CW-1:0]   vn_s2 [3];
	logic signed [DTW-1:0]  dot_s2;

	// Stage 3: c = -dot rounded half away from zero to the normal's format.
	logic [DTW-1:0]         dot_mag;
	logic [DTW:0]           dot_rnd;
	logic [DTW:0]           dot_shf;
	logic                   v_s3, z_s3;
	logic signed [CW-1:0]   n_s3 [3];
	logic signed [CW-1:0]   vn_s3 [3];
	logic [CMW-1:0]         cm_s3;
	logic                   cneg_s3;

	assign dot_mag = dot_s2[DTW-1] ? DTW'(-dot_s2) : DTW'(dot_s2);
	assign dot_rnd = {1'b0, dot_mag} + ((DTW+1)'(1) << (F - 1));
	assign dot_shf = dot_rnd >> F;

	// Stage 4: magnitude of c times each normal component, before scaling.
	logic                   v_s4, z_s4;
	logic signed [CW-1:0]   vn_s4 [3];
	logic [PRW-1:0]         p_s4 [3];
	logic [2:0]             pneg_s4;

	// Stage 5: scaled and rounded term.
	logic [PRW:0]           p_rnd [3];
	logic [PRW:0]           p_shf [3];
	logic                   v_s5, z_s5;
	logic signed [CW-1:0]   vn_s5 [3];
	logic [RW-1:0]          q_s5 [3];
	logic [2:0]             pneg_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_rnd[i] = {1'b0, p_s4[i]} + ((PRW+1)'(1) << (F - 2));
			p_shf[i] = p_rnd[i] >> (F - 1);
		end
	end

	// Stage 6: reflected sum r = vn + 2cn.
	logic signed [RW:0]     q_sgn [3];
	logic                   v_s6, z_s6;
	logic signed [RW:0]     r_s6 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_sgn[i] = $signed({1'b0, q_s5[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= stat1.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= stat1.zero;
			for (int i = 0; i < 3; i++) begin
				n_s1[i]    <= $signed(nrm1[i*CW +: CW]);
				vn_s1[i]   <= $signed(vn1[i]);
				prod_s1[i] <= $signed(nrm1[i*CW +: CW]) * $signed(vn1[i]);
			end

			z_s2   <= z_s1;
			n_s2   <= n_s1;
			vn_s2  <= vn_s1;
			dot_s2 <= DTW'(prod_s1[0]) + DTW'(prod_s1[1]) + DTW'(prod_s1[2]);

			z_s3    <= z_s2;
			n_s3    <= n_s2;
			vn_s3   <= vn_s2;
			cm_s3   <= CMW'(dot_shf);
			cneg_s3 <= !dot_s2[DTW-1] && (dot_shf != '0);

			z_s4  <= z_s3;
			vn_s4 <= vn_s3;
			for (int i = 0; i < 3; i++) begin
				p_s4[i]    <= cm_s3 * (n_s3[i][CW-1] ? CW'(-n_s3[i]) : CW'(n_s3[i]));
				pneg_s4[i] <= cneg_s3 != n_s3[i][CW-1];
			end

			z_s5    <= z_s4;
			vn_s5   <= vn_s4;
			pneg_s5 <= pneg_s4;
			for (int i = 0; i < 3; i++) begin
				q_s5[i] <= RW'(p_shf[i]);
			end

			z_s6 <= z_s5;
			for (int i = 0; i < 3; i++) begin
				r_s6[i] <= (RW+1)'(vn_s5[i]) + (pneg_s5[i] ? -q_sgn[i] : q_sgn[i]);
			end
		end
	end

	// Reflected sum into sign and magnitude form for the second normaliser.
	logic [2:0]         r_neg;
	logic [2:0][RW-1:0] r_mag;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_neg[i] = r_s6[i][RW];
			r_mag[i] = r_neg[i] ? RW'(-r_s6[i]) : RW'(r_s6[i]);
		end
	end

	vr3_stat_t          stat2;
	logic [2:0][CW-1:0] res2;
	logic               zin2;

	vr3_norm #(
		.IN_WIDTH        (RW),
		.COMPONENT_WIDTH (CW),
		.FRACTION_BITS   (F),
		.SIDE_WIDTH      (1)
	) u_norm_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (v_s6),
		.neg      (r_neg),
		.mag      (r_mag),
		.side     (z_s6),
		.stat     (stat2),
		.vec      (res2),
		.side_out (zin2)
	);

	// Either normalisation meeting a zero vector makes the whole item degenerate.
	assign out_valid   = stat2.valid;
	assign degenerate  = zin2 || stat2.zero;
	assign reflected_x = degenerate ? '0 : $signed(res2[0]);
	assign reflected_y = degenerate ? '0 : $signed(res2[1]);
	assign reflected_z = degenerate ? '0 : $signed(res2[2]);

endmodule
